// ===== rtl/core/multichannel_fm_phasor_synth_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the FM phasor synthesizer checker
// Concurrent checks on clk with the asynchronous reset masked.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_FM_PHASOR_SYNTH_UNIT_ASSERT_SVH
`define MULTICHANNEL_FM_PHASOR_SYNTH_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("synth unit check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define MFPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("synth unit check failed one cycle later");

`endif

// ===== rtl/core/mfps_pkg.sv =====
// ----------------------------------------------------------------------------
// mfps_pkg
// Types, constants and fixed-point helpers for the FM phasor synthesizer.
// ----------------------------------------------------------------------------
package mfps_pkg;

	// Q2.16 phasor width and fixed constants.
	localparam int PH_W = 18;
	localparam logic signed [17:0] Q18_MAX = 18'sh1FFFF;
	localparam logic signed [17:0] Q18_MIN = 18'sh20000;
	localparam logic signed [17:0] Q16_ONE = 18'sd65536;
	localparam logic signed [24:0] MSG_SCALE = 25'sd36045;

	// Sequencer lengths.
	localparam int CHAN_LEN  = 23;
	localparam int OUT_LEN   = 4;
	localparam int RMAG_LEN  = 4;
	localparam int SQRT_ITER = 26;
	localparam int DIV_ITER  = 42;

	// Configuration register indexes.
	localparam logic [1:0] REG_ACTIVE   = 2'd0;
	localparam logic [1:0] REG_FM_GAIN  = 2'd1;
	localparam logic [1:0] REG_OUT_GAIN = 2'd2;

	// Phasor selection during renormalization.
	localparam logic [1:0] PH_TONE = 2'd0;
	localparam logic [1:0] PH_CAR  = 2'd1;
	localparam logic [1:0] PH_DEV  = 2'd2;

	typedef struct packed {
		logic signed [17:0] re;
		logic signed [17:0] im;
	} cplx_t;

	localparam cplx_t CPLX_ONE = '{re: Q16_ONE, im: 18'sd0};

	// Micro-operations of the shared multiplier.
	typedef enum logic [4:0] {
		U_NOP, U_T0, U_T1, U_T2, U_T3, U_C0, U_C1, U_C2, U_C3,
		U_MSG, U_DEVD, U_H, U_D0, U_D1, U_D2, U_D3,
		U_X0, U_X1, U_X2, U_X3, U_ORE, U_OIM, U_SQ0, U_SQ1
	} uop_t;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_CHAN = 7'b0000010,
		ST_OUT  = 7'b0000100,
		ST_EMIT = 7'b0001000,
		ST_RMAG = 7'b0010000,
		ST_SQRT = 7'b0100000,
		ST_DIV  = 7'b1000000
	} state_t;

	// Per-channel program; bubbles let a result land before it is read.
	function automatic uop_t chan_uop(input logic [4:0] idx);
		uop_t u;
		case (idx)
			5'd0:  u = U_T0;
			5'd1:  u = U_T1;
			5'd2:  u = U_T2;
			5'd3:  u = U_T3;
			5'd4:  u = U_C0;
			5'd5:  u = U_C1;
			5'd6:  u = U_C2;
			5'd7:  u = U_C3;
			5'd8:  u = U_MSG;
			5'd10: u = U_DEVD;
			5'd12: u = U_H;
			5'd14: u = U_D0;
			5'd15: u = U_D1;
			5'd16: u = U_D2;
			5'd17: u = U_D3;
			5'd19: u = U_X0;
			5'd20: u = U_X1;
			5'd21: u = U_X2;
			5'd22: u = U_X3;
			default: u = U_NOP;
		endcase
		return u;
	endfunction

	// Output scaling program.
	function automatic uop_t out_uop(input logic [4:0] idx);
		uop_t u;
		case (idx)
			5'd1: u = U_ORE;
			5'd2: u = U_OIM;
			default: u = U_NOP;
		endcase
		return u;
	endfunction

	// Saturate a wide value to Q2.16.
	function automatic logic signed [17:0] sat18(input logic signed [49:0] v);
		logic signed [17:0] r;
		if (v > 50'(Q18_MAX))
			r = Q18_MAX;
		else if (v < 50'(Q18_MIN))
			r = Q18_MIN;
		else
			r = v[17:0];
		return r;
	endfunction

	// Round half up by 16 bits, then saturate to Q2.16.
	function automatic logic signed [17:0] rnd16_sat18(input logic signed [37:0] v);
		logic signed [37:0] r;
		r = (v + 38'sd32768) >>> 16;
		return sat18(50'(r));
	endfunction

	// Round half up by 17 bits, then saturate to a 16-bit sample.
	function automatic logic signed [15:0] rnd17_sat16(input logic signed [49:0] v);
		logic signed [49:0] r;
		logic signed [15:0] s;
		r = (v + 50'sd65536) >>> 17;
		if (r > 50'sd32767)
			s = 16'sh7FFF;
		else if (r < -50'sd32768)
			s = 16'sh8000;
		else
			s = r[15:0];
		return s;
	endfunction

	// Apply the sign to a magnitude quotient and saturate to Q2.16.
	function automatic logic signed [17:0] quot_sat(input logic [41:0] q, input logic neg);
		logic signed [17:0] r;
		if (neg)
			r = (q > 42'd131072) ? Q18_MIN : 18'(42'd0 - q);
		else
			r = (q > 42'd131071) ? Q18_MAX : 18'(q);
		return r;
	endfunction

endpackage

// ===== rtl/core/multichannel_fm_phasor_synth_unit.sv =====
// ----------------------------------------------------------------------------
// multichannel_fm_phasor_synth_unit
// Multi-channel FM test-signal synthesizer built from rotating phasors,
// sequenced over one shared 25x25 multiplier and one shared subtractor.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  input     in_valid / in_stall   mode, channel, tone_rot_*, carrier_rot_*
//  output    out_valid / out_stall sample_re, sample_im
//  config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// A load beat is taken in the idle state. A tick runs the channel program for
// every active channel and then the output program on the shared multiplier,
// one product per cycle. Every BLOCK ticks, each phasor (three per active
// channel) is renormalized: a 26-step square root and two 42-step divisions.
// The input is stalled while a tick or renormalization runs; a finished sample
// waits in the output register until taken. Reset restores all phasors to 1.
module multichannel_fm_phasor_synth_unit
	import mfps_pkg::*;
#(
	parameter int CHANNELS = 8,
	parameter int BLOCK    = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                mode,
	input  logic [2:0]          channel,
	input  logic signed [17:0]  tone_rot_re,
	input  logic signed [17:0]  tone_rot_im,
	input  logic signed [17:0]  carrier_rot_re,
	input  logic signed [17:0]  carrier_rot_im,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  sample_re,
	output logic signed [15:0]  sample_im,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [23:0]         cfg_data
);

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(CHANNELS + 1);
	localparam int SUM_W = PH_W + $clog2(CHANNELS);
	localparam int TK_W  = $clog2(BLOCK);

	// Sequencer state.
	state_t             state_q;
	logic [4:0]         op_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         ph_sel_q;
	logic               part_q;
	logic [5:0]         it_q;
	logic [TK_W-1:0]    ticks_q;
	logic               rn_due_q;

	// Configuration.
	logic [3:0]         active_q;
	logic [23:0]        fm_gain_q;
	logic [15:0]        out_gain_q;

	// Channel storage.
	cplx_t              tone_rot_q [CHANNELS];
	cplx_t              car_rot_q  [CHANNELS];
	cplx_t              tone_q     [CHANNELS];
	cplx_t              car_q      [CHANNELS];
	cplx_t              dev_q      [CHANNELS];

	// Multiplier pipeline and working values.
	logic signed [49:0] prod_s1;
	uop_t               uop_s1;
	logic [CH_W-1:0]    ch_s1;
	logic signed [37:0] acc_q;
	logic signed [17:0] tmp_re_q;
	logic signed [17:0] msg_q;
	logic signed [17:0] d_q;
	logic signed [17:0] step_re_q;
	logic signed [SUM_W-1:0] sum_re_q;
	logic signed [SUM_W-1:0] sum_im_q;
	logic signed [15:0] res_re_q;
	logic signed [15:0] res_im_q;

	// Root and divide unit.
	logic [27:0]        rem_q;
	logic [25:0]        root_q;
	logic [41:0]        quo_q;
	logic [51:0]        src_q;
	logic signed [17:0] rn_re_q;

	// Output register.
	logic               out_valid_q;
	logic signed [15:0] sample_re_q;
	logic signed [15:0] sample_im_q;

	logic [CNT_W-1:0]   n_ch;
	logic [CH_W-1:0]    idx;
	logic               last_ch;
	logic               in_acc;
	logic               out_free;
	logic [CH_W+2:0]    ch_wide;
	logic [CH_W-1:0]    ld_idx;
	logic               ld_hit;
	cplx_t              tn, tr, cp, cr, dv, rn;
	uop_t               cur_uop;
	logic signed [24:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [37:0] acc_nx;
	logic signed [17:0] fin;
	logic signed [49:0] msg_w;
	logic signed [49:0] d_w;
	logic signed [49:0] h_w;
	logic               sqrt_mode;
	logic [29:0]        shifted;
	logic [29:0]        trial;
	logic [30:0]        diff;
	logic               ge;
	logic signed [17:0] rn_v;
	logic [17:0]        rn_mag;
	logic [41:0]        div_num;
	logic signed [17:0] quot;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign sample_re = sample_re_q;
	assign sample_im = sample_im_q;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Effective channel count and the channel being worked on.
	always_comb begin
		if (int'(active_q) > CHANNELS)
			n_ch = CNT_W'(CHANNELS);
		else
			n_ch = CNT_W'(active_q);
	end

	assign idx     = cnt_q[CH_W-1:0];
	assign last_ch = ((cnt_q + CNT_W'(1)) == n_ch);

	// Load target; channels beyond the storage are ignored.
	assign ch_wide = {{CH_W{1'b0}}, channel};
	assign ld_idx  = ch_wide[CH_W-1:0];
	assign ld_hit  = (ch_wide < (CH_W+3)'(CHANNELS));

	// Channel operands, all read at the current channel.
	assign tn = tone_q[idx];
	assign tr = tone_rot_q[idx];
	assign cp = car_q[idx];
	assign cr = car_rot_q[idx];
	assign dv = dev_q[idx];

	always_comb begin
		case (ph_sel_q)
			PH_TONE: rn = tn;
			PH_CAR:  rn = cp;
			default: rn = dv;
		endcase
	end

	// Micro-operation issued this cycle.
	always_comb begin
		cur_uop = U_NOP;
		unique case (state_q)
			ST_CHAN: cur_uop = chan_uop(op_q);
			ST_OUT:  cur_uop = out_uop(op_q);
			ST_RMAG: begin
				if (op_q == 5'd0)
					cur_uop = U_SQ0;
				else if (op_q == 5'd1)
					cur_uop = U_SQ1;
			end
			default: cur_uop = U_NOP;
		endcase
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cur_uop)
			U_T0:  begin mul_a = 25'(tn.re); mul_b = 25'(tr.re); end
			U_T1:  begin mul_a = 25'(tn.im); mul_b = 25'(tr.im); end
			U_T2:  begin mul_a = 25'(tn.re); mul_b = 25'(tr.im); end
			U_T3:  begin mul_a = 25'(tn.im); mul_b = 25'(tr.re); end
			U_C0:  begin mul_a = 25'(cp.re); mul_b = 25'(cr.re); end
			U_C1:  begin mul_a = 25'(cp.im); mul_b = 25'(cr.im); end
			U_C2:  begin mul_a = 25'(cp.re); mul_b = 25'(cr.im); end
			U_C3:  begin mul_a = 25'(cp.im); mul_b = 25'(cr.re); end
			U_MSG: begin mul_a = MSG_SCALE; mul_b = 25'(tn.im); end
			U_DEVD: begin mul_a = signed'({1'b0, fm_gain_q}); mul_b = 25'(msg_q); end
			U_H:   begin mul_a = 25'(d_q); mul_b = 25'(d_q); end
			U_D0:  begin mul_a = 25'(dv.re); mul_b = 25'(step_re_q); end
			U_D1:  begin mul_a = 25'(dv.im); mul_b = 25'(d_q); end
			U_D2:  begin mul_a = 25'(dv.re); mul_b = 25'(d_q); end
			U_D3:  begin mul_a = 25'(dv.im); mul_b = 25'(step_re_q); end
			U_X0:  begin mul_a = 25'(cp.re); mul_b = 25'(dv.re); end
			U_X1:  begin mul_a = 25'(cp.im); mul_b = 25'(dv.im); end
			U_X2:  begin mul_a = 25'(cp.re); mul_b = 25'(dv.im); end
			U_X3:  begin mul_a = 25'(cp.im); mul_b = 25'(dv.re); end
			U_ORE: begin mul_a = 25'(sum_re_q); mul_b = signed'({9'd0, out_gain_q}); end
			U_OIM: begin mul_a = 25'(sum_im_q); mul_b = signed'({9'd0, out_gain_q}); end
			U_SQ0: begin mul_a = 25'(rn.re); mul_b = 25'(rn.re); end
			U_SQ1: begin mul_a = 25'(rn.im); mul_b = 25'(rn.im); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// Accumulation of the registered product.
	always_comb begin
		unique case (uop_s1) inside
			U_T0, U_T2, U_C0, U_C2, U_D0, U_D2, U_X0, U_X2, U_SQ0:
				acc_nx = prod_s1[37:0];
			U_T1, U_C1, U_D1, U_X1:
				acc_nx = acc_q - prod_s1[37:0];
			U_T3, U_C3, U_D3, U_X3, U_SQ1:
				acc_nx = acc_q + prod_s1[37:0];
			default:
				acc_nx = acc_q;
		endcase
	end

	assign fin   = rnd16_sat18(acc_nx);
	assign msg_w = (prod_s1 + 50'sd32768) >>> 16;
	assign d_w   = (prod_s1 + 50'sd8388608) >>> 24;
	assign h_w   = 50'sd65536 - ((prod_s1 + 50'sd65536) >>> 17);

	// Shared subtractor for the square root and the divisions.
	assign sqrt_mode = (state_q == ST_SQRT);
	assign shifted   = sqrt_mode ? {rem_q, src_q[51:50]} : {1'b0, rem_q, src_q[51]};
	assign trial     = sqrt_mode ? {2'b00, root_q, 2'b01} : {4'b0000, root_q};
	assign diff      = {1'b0, shifted} - {1'b0, trial};
	assign ge        = !diff[30];

	// Dividend for the phasor part being normalized.
	assign rn_v    = part_q ? rn.im : rn.re;
	assign rn_mag  = rn_v[17] ? 18'(18'd0 - rn_v) : rn_v;
	assign div_num = {rn_mag, 24'd0} + 42'(root_q[25:1]);
	assign quot    = quot_sat(quo_q, rn_v[17]);

	// Sequencer, configuration, storage and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= '0;
			cnt_q       <= '0;
			ph_sel_q    <= PH_TONE;
			part_q      <= 1'b0;
			it_q        <= '0;
			ticks_q     <= '0;
			rn_due_q    <= 1'b0;
			uop_s1      <= U_NOP;
			active_q    <= 4'd1;
			fm_gain_q   <= 24'd0;
			out_gain_q  <= 16'd52429;
			out_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				tone_rot_q[c] <= CPLX_ONE;
				car_rot_q[c]  <= CPLX_ONE;
				tone_q[c]     <= CPLX_ONE;
				car_q[c]      <= CPLX_ONE;
				dev_q[c]      <= CPLX_ONE;
			end
		end else begin
			uop_s1 <= cur_uop;

			// Register writes.
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_ACTIVE:   active_q   <= cfg_data[3:0];
					REG_FM_GAIN:  fm_gain_q  <= cfg_data;
					REG_OUT_GAIN: out_gain_q <= cfg_data[15:0];
					default: ;
				endcase
			end

			// Output beat leaves; a new sample in the same cycle is set below.
			if (out_valid_q && !out_stall && state_q != ST_EMIT)
				out_valid_q <= 1'b0;

			// Finished complex products land in storage.
			if (uop_s1 == U_T3)
				tone_q[ch_s1] <= '{re: tmp_re_q, im: fin};
			if (uop_s1 == U_C3)
				car_q[ch_s1] <= '{re: tmp_re_q, im: fin};
			if (uop_s1 == U_D3)
				dev_q[ch_s1] <= '{re: tmp_re_q, im: fin};

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && mode) begin
						if (ld_hit) begin
							tone_rot_q[ld_idx] <= '{re: tone_rot_re, im: tone_rot_im};
							car_rot_q[ld_idx]  <= '{re: carrier_rot_re, im: carrier_rot_im};
							tone_q[ld_idx]     <= CPLX_ONE;
							car_q[ld_idx]      <= CPLX_ONE;
							dev_q[ld_idx]      <= CPLX_ONE;
						end
					end else if (in_acc) begin
						cnt_q <= '0;
						op_q  <= '0;
						if (ticks_q == TK_W'(BLOCK - 1)) begin
							ticks_q  <= '0;
							rn_due_q <= 1'b1;
						end else begin
							ticks_q  <= ticks_q + TK_W'(1);
							rn_due_q <= 1'b0;
						end
						state_q <= (n_ch == '0) ? ST_OUT : ST_CHAN;
					end
				end
				ST_CHAN: begin
					if (op_q == 5'(CHAN_LEN - 1)) begin
						op_q <= '0;
						if (last_ch)
							state_q <= ST_OUT;
						else
							cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						op_q <= op_q + 5'd1;
					end
				end
				ST_OUT: begin
					if (op_q == 5'(OUT_LEN - 1))
						state_q <= ST_EMIT;
					else
						op_q <= op_q + 5'd1;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						cnt_q       <= '0;
						ph_sel_q    <= PH_TONE;
						op_q        <= '0;
						state_q     <= (rn_due_q && n_ch != '0) ? ST_RMAG : ST_IDLE;
					end
				end
				ST_RMAG: begin
					if (op_q == 5'(RMAG_LEN - 1)) begin
						it_q    <= '0;
						state_q <= ST_SQRT;
					end else begin
						op_q <= op_q + 5'd1;
					end
				end
				ST_SQRT: begin
					if (it_q == 6'(SQRT_ITER - 1)) begin
						op_q    <= '0;
						part_q  <= 1'b0;
						state_q <= ST_DIV;
					end else begin
						it_q <= it_q + 6'd1;
					end
				end
				ST_DIV: begin
					if (op_q == 5'd0 && root_q != '0) begin
						op_q <= 5'd1;
						it_q <= '0;
					end else if (op_q == 5'd1) begin
						if (it_q == 6'(DIV_ITER - 1))
							op_q <= 5'd2;
						else
							it_q <= it_q + 6'd1;
					end else if (op_q == 5'd2 && !part_q) begin
						part_q <= 1'b1;
						op_q   <= 5'd0;
					end else begin
						// Phasor done, or left alone at zero magnitude.
						if (op_q == 5'd2) begin
							unique case (ph_sel_q)
								PH_TONE: tone_q[idx] <= '{re: rn_re_q, im: quot};
								PH_CAR:  car_q[idx]  <= '{re: rn_re_q, im: quot};
								default: dev_q[idx]  <= '{re: rn_re_q, im: quot};
							endcase
						end
						op_q <= '0;
						if (ph_sel_q == PH_TONE) begin
							ph_sel_q <= PH_CAR;
							state_q  <= ST_RMAG;
						end else if (ph_sel_q == PH_CAR) begin
							ph_sel_q <= PH_DEV;
							state_q  <= ST_RMAG;
						end else begin
							ph_sel_q <= PH_TONE;
							if (last_ch) begin
								state_q <= ST_IDLE;
							end else begin
								cnt_q   <= cnt_q + CNT_W'(1);
								state_q <= ST_RMAG;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		ch_s1   <= idx;
		acc_q   <= acc_nx;

		// Results of finished multiplier steps.
		case (uop_s1) inside
			U_T1, U_C1, U_D1, U_X1: tmp_re_q <= fin;
			U_MSG:  msg_q     <= msg_w[17:0];
			U_DEVD: d_q       <= d_w[17:0];
			U_H:    step_re_q <= sat18(h_w);
			U_ORE:  res_re_q  <= rnd17_sat16(prod_s1);
			U_OIM:  res_im_q  <= rnd17_sat16(prod_s1);
			default: ;
		endcase

		// Channel terms add up exactly; a tick starts from zero.
		if (state_q == ST_IDLE && in_acc && !mode) begin
			sum_re_q <= '0;
			sum_im_q <= '0;
		end else if (uop_s1 == U_X3) begin
			sum_re_q <= sum_re_q + SUM_W'(tmp_re_q);
			sum_im_q <= sum_im_q + SUM_W'(fin);
		end

		// Sample into the output register.
		if (state_q == ST_EMIT && out_free) begin
			sample_re_q <= res_re_q;
			sample_im_q <= res_im_q;
		end

		// Square root of the squared magnitude scaled by 2^16.
		if (state_q == ST_RMAG && op_q == 5'(RMAG_LEN - 1)) begin
			src_q  <= {acc_q[35:0], 16'd0};
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == ST_SQRT) begin
			rem_q  <= ge ? diff[27:0] : shifted[27:0];
			root_q <= {root_q[24:0], ge};
			src_q  <= {src_q[49:0], 2'b00};
		end

		// Restoring division of one part by the magnitude.
		if (state_q == ST_DIV) begin
			if (op_q == 5'd0) begin
				src_q <= {div_num, 10'd0};
				rem_q <= '0;
				quo_q <= '0;
			end else if (op_q == 5'd1) begin
				rem_q <= ge ? diff[27:0] : shifted[27:0];
				quo_q <= {quo_q[40:0], ge};
				src_q <= {src_q[50:0], 1'b0};
			end else if (!part_q) begin
				rn_re_q <= quot;
			end
		end
	end

endmodule

// ===== rtl/core/mfps_chk.sv =====
// ----------------------------------------------------------------------------
// mfps_chk
// Port-level checks for the FM phasor synthesizer, bound to the top level.
// ----------------------------------------------------------------------------
module mfps_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               mode,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] sample_re,
	input logic signed [15:0] sample_im
);

`include "multichannel_fm_phasor_synth_unit_assert.svh"

	// A waiting sample stays offered and unchanged.
	`MFPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_re) && $stable(sample_im))

	// A load beat finishes at once, so the input is open again next cycle.
	`MFPS_ASSERT_NEXT(a_load_quick, in_valid && !in_stall && mode, !in_stall)

	// A tick beat keeps the block busy on the following cycle.
	`MFPS_ASSERT_NEXT(a_tick_busy, in_valid && !in_stall && !mode, in_stall)

	// A new sample is only raised from inside a tick.
	`MFPS_ASSERT_NOW(a_out_from_tick, $rose(out_valid), $past(in_stall))

endmodule

bind multichannel_fm_phasor_synth_unit mfps_chk u_mfps_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.mode      (mode),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.sample_re (sample_re),
	.sample_im (sample_im)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multichannel FM phasor synthesizer. A driver
// offers load and tick beats from a queue of pending items, a bit-exact
// phasor predictor computes the expected sample of every tick, and a monitor
// compares each sample taken from the output. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	import mfps_pkg::*;

	localparam int NCH = 8;
	localparam int RENORM_TICKS = 4096;
	localparam int SETTLE_CYCLES = 3000;

	// Register index with no register behind it.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic              mode;
		logic [2:0]        channel;
		logic signed [17:0] trot_re;
		logic signed [17:0] trot_im;
		logic signed [17:0] crot_re;
		logic signed [17:0] crot_im;
	} synth_item_t;

	typedef struct {
		logic signed [15:0] re;
		logic signed [15:0] im;
	} sample_t;

	typedef struct {
		longint re;
		longint im;
	} phasor_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic [2:0] channel = '0;
	logic signed [17:0] tone_rot_re = '0;
	logic signed [17:0] tone_rot_im = '0;
	logic signed [17:0] carrier_rot_re = '0;
	logic signed [17:0] carrier_rot_im = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] sample_re;
	logic signed [15:0] sample_im;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	multichannel_fm_phasor_synth_unit dut (.*);

	always #6 clk = ~clk;

	// Pending beats, expected samples and shared bench flags.
	synth_item_t pending_items[$];
	sample_t expected_samples[$];
	int errors = 0;
	bit sender_steady = 1'b0;
	bit receiver_steady = 1'b0;
	int hold_requests = 0;

	// Predictor state: rotations, phasors and the shadow registers.
	phasor_t tone_rot[NCH], car_rot[NCH], tone_ph[NCH], car_ph[NCH], dev_ph[NCH];
	int tick_count = 0;
	int unsigned act_reg = 1;
	longint fm_gain_reg = 0;
	longint out_gain_reg = 52429;

	// Round half up by s bits.
	function automatic longint rnd_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp_q18(longint v);
		return v > 131071 ? 131071 : (v < -131072 ? -131072 : v);
	endfunction

	function automatic phasor_t phasor_mul(phasor_t a, phasor_t b);
		phasor_t r;
		r.re = clamp_q18(rnd_shift(a.re * b.re - a.im * b.im, 16));
		r.im = clamp_q18(rnd_shift(a.re * b.im + a.im * b.re, 16));
		return r;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint unit_part(longint v, longint unsigned m);
		longint unsigned mag;
		longint q;
		mag = v < 0 ? -v : v;
		q = ((mag << 24) + (m >> 1)) / m;
		return clamp_q18(v < 0 ? -q : q);
	endfunction

	function automatic phasor_t to_unit(phasor_t p);
		longint unsigned m;
		phasor_t r;
		m = floor_sqrt((longint'(p.re * p.re) + longint'(p.im * p.im)) << 16);
		if (m == 0)
			return p;
		r.re = unit_part(p.re, m);
		r.im = unit_part(p.im, m);
		return r;
	endfunction

	function automatic longint clamp_sample(longint v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	// Advance the phasor state for one accepted beat.
	task automatic synth_advance(synth_item_t it);
		int n;
		longint acc_re, acc_im, msg, dv, hv;
		phasor_t stp, term;
		sample_t s;
		n = act_reg > NCH ? NCH : act_reg;
		acc_re = 0;
		acc_im = 0;
		if (it.mode) begin
			tone_rot[it.channel] = '{it.trot_re, it.trot_im};
			car_rot[it.channel] = '{it.crot_re, it.crot_im};
			tone_ph[it.channel] = '{65536, 0};
			car_ph[it.channel] = '{65536, 0};
			dev_ph[it.channel] = '{65536, 0};
			return;
		end
		for (int c = 0; c < n; c++) begin
			tone_ph[c] = phasor_mul(tone_ph[c], tone_rot[c]);
			msg = rnd_shift(36045 * tone_ph[c].im, 16);
			dv = rnd_shift(fm_gain_reg * msg, 24);
			hv = rnd_shift(dv * dv, 17);
			stp.re = clamp_q18(65536 - hv);
			stp.im = clamp_q18(dv);
			dev_ph[c] = phasor_mul(dev_ph[c], stp);
			car_ph[c] = phasor_mul(car_ph[c], car_rot[c]);
			term = phasor_mul(car_ph[c], dev_ph[c]);
			acc_re += term.re;
			acc_im += term.im;
		end
		s.re = clamp_sample(rnd_shift(acc_re * out_gain_reg, 17));
		s.im = clamp_sample(rnd_shift(acc_im * out_gain_reg, 17));
		expected_samples.push_back(s);
		tick_count++;
		if (tick_count >= RENORM_TICKS) begin
			tick_count = 0;
			for (int c = 0; c < n; c++) begin
				tone_ph[c] = to_unit(tone_ph[c]);
				car_ph[c] = to_unit(car_ph[c]);
				dev_ph[c] = to_unit(dev_ph[c]);
			end
		end
	endtask

	// Mostly short gaps, a few long ones.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Driver: offer pending beats, predict each one as it is taken.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		synth_item_t it;
		logic next_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			next_valid = in_valid;
			if (in_valid && !in_stall) begin
				synth_advance('{mode, channel, tone_rot_re, tone_rot_im,
					carrier_rot_re, carrier_rot_im});
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_items.size() > 0) begin
					it = pending_items.pop_front();
					mode <= it.mode;
					channel <= it.channel;
					tone_rot_re <= it.trot_re;
					tone_rot_im <= it.trot_im;
					carrier_rot_re <= it.crot_re;
					carrier_rot_im <= it.crot_im;
					next_valid = 1'b1;
					send_gap = sender_steady ? 0 : idle_len();
				end
			end
			in_valid <= next_valid;
		end
	end

	// Monitor: compare each sample beat and drive the output stall.
	int stall_left = 0;
	int holds_done = 0;
	always @(posedge clk or negedge arst_n) begin
		sample_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					$error("sample beat with nothing expected: re %0d im %0d",
						sample_re, sample_im);
					errors++;
				end else begin
					e = expected_samples.pop_front();
					if (sample_re !== e.re) begin
						$error("sample_re: expected %0d, actual %0d", e.re, sample_re);
						errors++;
					end
					if (sample_im !== e.im) begin
						$error("sample_im: expected %0d, actual %0d", e.im, sample_im);
						errors++;
					end
				end
			end
			if (holds_done != hold_requests) begin
				holds_done++;
				stall_left = 600;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = receiver_steady ? 0 : idle_len();
				out_stall <= stall_left > 0;
			end
		end
	end

	// Wait until every beat is taken and every sample has come back.
	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ACTIVE:   act_reg = val[3:0];
			REG_FM_GAIN:  fm_gain_reg = val;
			REG_OUT_GAIN: out_gain_reg = val[15:0];
			default: ;
		endcase
	endtask

	function automatic synth_item_t load_beat(int ch, int tr, int ti, int cr, int ci);
		return '{1'b1, ch[2:0], tr[17:0], ti[17:0], cr[17:0], ci[17:0]};
	endfunction

	function automatic synth_item_t tick_beat();
		synth_item_t it;
		it.mode = 1'b0;
		it.channel = 3'($urandom);
		it.trot_re = 18'($urandom);
		it.trot_im = 18'($urandom);
		it.crot_re = 18'($urandom);
		it.crot_im = 18'($urandom);
		return it;
	endfunction

	// Load with a near-unit rotation most of the time, raw bits otherwise.
	function automatic synth_item_t random_load();
		synth_item_t it;
		real ta, ca;
		it = tick_beat();
		it.mode = 1'b1;
		if ($urandom_range(0, 9) < 8) begin
			ta = ($urandom_range(0, 20000) - 10000.0) / 10000.0 * 0.4;
			ca = ($urandom_range(0, 20000) - 10000.0) / 10000.0 * 3.1;
			it.trot_re = 18'($rtoi($cos(ta) * 65536.0));
			it.trot_im = 18'($rtoi($sin(ta) * 65536.0));
			it.crot_re = 18'($rtoi($cos(ca) * 65536.0));
			it.crot_im = 18'($rtoi($sin(ca) * 65536.0));
		end
		return it;
	endfunction

	// One phase: load every channel, then mostly ticks with some reloads.
	task automatic run_phase(int count);
		for (int c = 0; c < NCH; c++) begin
			synth_item_t it;
			it = random_load();
			it.channel = 3'(c);
			pending_items.push_back(it);
		end
		for (int i = 0; i < count; i++)
			pending_items.push_back($urandom_range(0, 9) == 0 ? random_load() : tick_beat());
		wait_drained();
	endtask

	initial begin
		for (int c = 0; c < NCH; c++) begin
			tone_rot[c] = '{65536, 0};
			car_rot[c] = '{65536, 0};
			tone_ph[c] = '{65536, 0};
			car_ph[c] = '{65536, 0};
			dev_ph[c] = '{65536, 0};
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset defaults, then extreme rotations on every channel.
		pending_items.push_back(tick_beat());
		pending_items.push_back(tick_beat());
		wait_drained();
		reg_write(REG_ACTIVE, 24'd8);
		reg_write(REG_FM_GAIN, 24'hFFFFFF);
		reg_write(REG_OUT_GAIN, 24'd65535);
		pending_items.push_back(load_beat(0, 131071, -131072, -131072, 131071));
		pending_items.push_back(load_beat(1, -131072, 131071, 131071, -131072));
		pending_items.push_back(load_beat(2, 0, 0, 0, 0));
		pending_items.push_back(load_beat(3, 131071, 131071, 131071, 131071));
		pending_items.push_back(load_beat(4, -131072, -131072, -131072, -131072));
		pending_items.push_back(load_beat(5, 0, 65536, 0, -65536));
		pending_items.push_back(load_beat(6, 46341, 46341, -46341, 46341));
		pending_items.push_back(load_beat(7, 65536, 0, 65536, 0));
		for (int i = 0; i < 6; i++)
			pending_items.push_back(tick_beat());
		wait_drained();
		// No channels, then a count above the channel total, then an unused index.
		reg_write(REG_ACTIVE, 24'd0);
		pending_items.push_back(tick_beat());
		pending_items.push_back(load_beat(3, 65536, 0, 0, 65536));
		pending_items.push_back(tick_beat());
		wait_drained();
		reg_write(REG_ACTIVE, 24'd15);
		reg_write(REG_UNUSED, 24'hABCDEF);
		pending_items.push_back(tick_beat());
		pending_items.push_back(tick_beat());
		wait_drained();

		// Random phases over several register settings.
		reg_write(REG_ACTIVE, 24'd1);
		reg_write(REG_FM_GAIN, 24'd0);
		reg_write(REG_OUT_GAIN, 24'd52429);
		sender_steady = 1'b1;
		hold_requests++;
		run_phase(240);
		sender_steady = 1'b0;

		reg_write(REG_ACTIVE, 24'd8);
		reg_write(REG_FM_GAIN, 24'hFFFFFF);
		reg_write(REG_OUT_GAIN, 24'd65535);
		run_phase(220);

		reg_write(REG_ACTIVE, 24'($urandom_range(2, 7)));
		reg_write(REG_FM_GAIN, 24'($urandom));
		reg_write(REG_OUT_GAIN, 24'($urandom));
		receiver_steady = 1'b1;
		run_phase(220);
		receiver_steady = 1'b0;

		reg_write(REG_ACTIVE, 24'd0);
		reg_write(REG_OUT_GAIN, 24'd0);
		run_phase(100);

		reg_write(REG_ACTIVE, 24'd15);
		reg_write(REG_FM_GAIN, 24'($urandom_range(0, 24'h3FFFFF)));
		reg_write(REG_OUT_GAIN, 24'd13107);
		sender_steady = 1'b1;
		receiver_steady = 1'b1;
		run_phase(200);
		sender_steady = 1'b0;
		receiver_steady = 1'b0;

		reg_write(REG_ACTIVE, 24'($urandom_range(1, 8)));
		reg_write(REG_FM_GAIN, 24'($urandom));
		reg_write(REG_OUT_GAIN, 24'($urandom));
		hold_requests++;
		run_phase(260);

		reg_write(REG_ACTIVE, 24'd1);
		reg_write(REG_FM_GAIN, 24'd838861);
		reg_write(REG_OUT_GAIN, 24'd65535);
		run_phase(200);

		if (expected_samples.size() != 0) begin
			$error("%0d expected samples never arrived", expected_samples.size());
			errors++;
		end
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Run limit.
	initial begin
		#60000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== multichannel_fm_phasor_synth_unit.f =====
+incdir+rtl/core
rtl/core/mfps_pkg.sv
rtl/core/multichannel_fm_phasor_synth_unit.sv
rtl/core/mfps_chk.sv
tb/tb_top.sv
